@@ src/tlb_second_chance_unit_macros.svh @@
// Assertion macros shared by the TLB second-chance unit modules.
// No dependencies; included by the files that carry concurrent checks.
`ifndef TLB_SECOND_CHANCE_UNIT_MACROS_SVH
`define TLB_SECOND_CHANCE_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset
`define TSCU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tlb second chance check failed");

// Next-cycle implication, disabled during reset
`define TSCU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tlb second chance check failed");

`else

`define TSCU_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define TSCU_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

@@ src/tlbsc_pkg.sv @@
// Shared constants and types for the TLB second-chance unit.
// No dependencies; imported by every module of the block.
package tlbsc_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int IDX_W       = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    localparam int TAG_W    = 36;
    localparam int OFF_W    = 27;
    localparam int ADDR_W   = 63;
    localparam int CALC_W   = 64;
    localparam int SHIFT_W  = 5;
    localparam int SLOT_W   = 4;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;
    localparam logic               REQ_WRITE   = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cap_req;  // load the request registers
        logic commit;   // look up, update the entries, load the result
    } tlbsc_cmd_t;

endpackage

@@ src/tlbsc_ctrl.sv @@
// Controller FSM for the TLB second-chance unit: handshakes and sequencing.
// Depends on tlbsc_pkg and tlb_second_chance_unit_macros.svh.
`include "tlb_second_chance_unit_macros.svh"

module tlbsc_ctrl
    import tlbsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output tlbsc_cmd_t cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_LOOKUP = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    // Result register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.cap_req = (state_reg == S_IDLE) && in_valid;
    assign cmd.commit  = (state_reg == S_LOOKUP) && out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        priority if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Checks
    `TSCU_ASSERT_IMP(a_commit_free, clk, rst_n, cmd.commit, !out_valid_reg || out_ready)
    `TSCU_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)
    `TSCU_ASSERT_IMP(a_valid_src, clk, rst_n, $rose(out_valid_reg), $past(cmd.commit))

endmodule

@@ src/tlbsc_dp.sv @@
// Datapath of the TLB second-chance unit: entries, tag match, victim choice,
// result registers and address formation. Depends on tlbsc_pkg and the macros.
`include "tlb_second_chance_unit_macros.svh"

module tlbsc_dp
    import tlbsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tlbsc_cmd_t         cmd,
    input  logic               cfg_we,
    input  logic [SHIFT_W-1:0] cfg_wdata,
    input  logic               req_type,
    input  logic [TAG_W-1:0]   vpn,
    input  logic [OFF_W-1:0]   page_offset,
    input  logic [TAG_W-1:0]   refill_pfn,
    output logic [ADDR_W-1:0]  phys_addr,
    output logic               hit,
    output logic [SLOT_W-1:0]  slot
);

    // Lowest set bit of a per-entry vector
    function automatic logic [IDX_W-1:0] first_set(input logic [TLB_ENTRIES-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int k = TLB_ENTRIES - 1; k >= 0; k--)
        begin
            if (vec[k])
                idx = IDX_W'(k);
        end
        return idx;
    endfunction

    logic                   req_type_reg;
    logic [TAG_W-1:0]       req_vpn_reg;
    logic [OFF_W-1:0]       req_off_reg;
    logic [TAG_W-1:0]       req_pfn_reg;
    logic [SHIFT_W-1:0]     page_shift_reg;

    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [TLB_ENTRIES-1:0] valid_next;
    logic [TLB_ENTRIES-1:0] used_reg;
    logic [TLB_ENTRIES-1:0] used_next;
    logic [TLB_ENTRIES-1:0] dirty_reg;
    logic [TLB_ENTRIES-1:0] dirty_next;
    logic [TAG_W-1:0]       tag_mem [TLB_ENTRIES];
    logic [TAG_W-1:0]       frame_mem [TLB_ENTRIES];

    logic [TAG_W-1:0]       res_frame_reg;
    logic [OFF_W-1:0]       res_off_reg;
    logic                   res_hit_reg;
    logic [SLOT_W-1:0]      res_slot_reg;

    logic [TLB_ENTRIES-1:0] match;
    logic                   hit_any;
    logic [IDX_W-1:0]       hit_idx;
    logic                   inv_any;
    logic [IDX_W-1:0]       inv_idx;
    logic                   unused_any;
    logic [IDX_W-1:0]       unused_idx;
    logic [IDX_W-1:0]       fill_idx;
    logic [IDX_W-1:0]       sel_idx;
    logic [CALC_W-1:0]      shifted;

    // Parallel tag compare against valid entries
    always_comb
    begin
        for (int k = 0; k < TLB_ENTRIES; k++)
            match[k] = valid_reg[k] && (tag_mem[k] == req_vpn_reg);
    end

    assign hit_any    = |match;
    assign hit_idx    = first_set(match);
    assign inv_any    = !(&valid_reg);
    assign inv_idx    = first_set(~valid_reg);
    assign unused_any = !(&used_reg);
    assign unused_idx = first_set(~used_reg);

    // Victim: lowest invalid entry, else first entry with used clear,
    // else entry 0 once the sweep has cleared every used bit
    always_comb
    begin
        priority if (inv_any)
            fill_idx = inv_idx;
        else if (unused_any)
            fill_idx = unused_idx;
        else
            fill_idx = '0;
    end

    assign sel_idx = hit_any ? hit_idx : fill_idx;

    // Status bit updates for hit and refill
    always_comb
    begin
        valid_next = valid_reg;
        used_next  = used_reg;
        dirty_next = dirty_reg;
        if (hit_any)
        begin
            used_next[hit_idx] = 1'b1;
            if (req_type_reg == REQ_WRITE)
                dirty_next[hit_idx] = 1'b1;
        end
        else
        begin
            // sweep clears used bits of the entries it passes over
            if (!inv_any)
            begin
                for (int k = 0; k < TLB_ENTRIES; k++)
                begin
                    if (!unused_any || (IDX_W'(k) < unused_idx))
                        used_next[k] = 1'b0;
                end
            end
            valid_next[fill_idx] = 1'b1;
            used_next[fill_idx]  = 1'b1;
            dirty_next[fill_idx] = (req_type_reg == REQ_WRITE);
        end
    end

    // Control-side state: status bits and page shift register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            used_reg       <= '0;
            dirty_reg      <= '0;
            page_shift_reg <= SHIFT_RESET;
        end
        else
        begin
            if (cmd.commit)
            begin
                valid_reg <= valid_next;
                used_reg  <= used_next;
                dirty_reg <= dirty_next;
            end
            if (cfg_we)
                page_shift_reg <= cfg_wdata;
        end
    end

    // Request capture, tag/frame store and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            req_type_reg <= req_type;
            req_vpn_reg  <= vpn;
            req_off_reg  <= page_offset;
            req_pfn_reg  <= refill_pfn;
        end
        if (cmd.commit)
        begin
            if (!hit_any)
            begin
                tag_mem[fill_idx]   <= req_vpn_reg;
                frame_mem[fill_idx] <= req_pfn_reg;
            end
            res_frame_reg <= hit_any ? frame_mem[hit_idx] : req_pfn_reg;
            res_off_reg   <= req_off_reg;
            res_hit_reg   <= hit_any;
            res_slot_reg  <= SLOT_W'(sel_idx);
        end
    end

    // Physical address: frame shifted in 64 bits, cut to the field width
    assign shifted   = {{(CALC_W-TAG_W){1'b0}}, res_frame_reg} << page_shift_reg;
    assign phys_addr = shifted[ADDR_W-1:0] | {{(ADDR_W-OFF_W){1'b0}}, res_off_reg};
    assign hit       = res_hit_reg;
    assign slot      = res_slot_reg;

    // Checks
    `TSCU_ASSERT_IMP(a_single_match, clk, rst_n, cmd.commit, $onehot0(match))
    `TSCU_ASSERT_NXT(a_sel_live, clk, rst_n, cmd.commit, valid_reg[$past(sel_idx)] && used_reg[$past(sel_idx)])

endmodule

@@ src/tlb_second_chance_unit.sv @@
// TLB second-chance unit: 16-entry fully associative TLB, clock replacement.
// The result is registered in the lookup-and-update state that follows the capture state;
// no new request is taken until that lookup has loaded the result register.
// A waiting result does not block the capture of the next request; its lookup waits.
// Reset clears all valid, used and dirty bits and sets page_shift to 12;
// tags and frames are not cleared, so the unit is ready right after reset.
module tlb_second_chance_unit
    import tlbsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SHIFT_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [TAG_W-1:0]   vpn,
    input  logic [OFF_W-1:0]   page_offset,
    input  logic [TAG_W-1:0]   refill_pfn,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  phys_addr,
    output logic               hit,
    output logic [SLOT_W-1:0]  slot
);

    tlbsc_cmd_t cmd;

    tlbsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    tlbsc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_type    (req_type),
        .vpn         (vpn),
        .page_offset (page_offset),
        .refill_pfn  (refill_pfn),
        .phys_addr   (phys_addr),
        .hit         (hit),
        .slot        (slot)
    );

endmodule

@@ verif/tlb_second_chance_checker.sv @@
// Transfer checker for the TLB second-chance unit: predicts each translation and compares it.
// Depends on tlbsc_pkg for widths, table size, reset shift and the write code.
`timescale 1ns / 100ps

module tlb_second_chance_checker
    import tlbsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SHIFT_W-1:0] cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               req_type,
    input  logic [TAG_W-1:0]   vpn,
    input  logic [OFF_W-1:0]   page_offset,
    input  logic [TAG_W-1:0]   refill_pfn,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [ADDR_W-1:0]  phys_addr,
    input  logic               hit,
    input  logic [SLOT_W-1:0]  slot,
    output int                 mismatch_count,
    output int                 xlate_pending
);

    localparam int SWEEP_PASSES = 2;

    typedef struct {
        logic [ADDR_W-1:0] phys_addr;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } xlate_t;

    // Shadow copy of the table and the shift register
    logic [SHIFT_W-1:0] cur_shift;
    logic               tlb_valid [TLB_ENTRIES];
    logic               tlb_used  [TLB_ENTRIES];
    logic               tlb_dirty [TLB_ENTRIES];
    logic [TAG_W-1:0]   tlb_tag   [TLB_ENTRIES];
    logic [TAG_W-1:0]   tlb_frame [TLB_ENTRIES];

    xlate_t xlate_due [$];

    // Look up one request, update the shadow table and return its translation
    function automatic xlate_t translate_req(logic wr, logic [TAG_W-1:0] va,
                                             logic [OFF_W-1:0] off, logic [TAG_W-1:0] pfn);
        xlate_t            r;
        int                k;
        int                pass;
        int                way;
        logic [CALC_W-1:0] wide;
        logic [TAG_W-1:0]  frame;

        way = -1;
        for (k = 0; k < TLB_ENTRIES; k++)
        begin
            if (way < 0 && tlb_valid[k] && tlb_tag[k] == va)
                way = k;
        end

        if (way >= 0)
        begin
            // hit: mark referenced, a write marks dirty
            tlb_used[way] = 1'b1;
            if (wr == REQ_WRITE)
                tlb_dirty[way] = 1'b1;
            frame = tlb_frame[way];
            r.hit = 1'b1;
        end
        else
        begin
            // miss: lowest free entry, else second-chance sweep from entry 0
            for (k = 0; k < TLB_ENTRIES; k++)
            begin
                if (way < 0 && !tlb_valid[k])
                    way = k;
            end
            for (pass = 0; pass < SWEEP_PASSES && way < 0; pass++)
            begin
                for (k = 0; k < TLB_ENTRIES && way < 0; k++)
                begin
                    if (!tlb_used[k])
                        way = k;
                    else
                        tlb_used[k] = 1'b0;
                end
            end
            if (way < 0)
                way = 0;
            tlb_valid[way] = 1'b1;
            tlb_used[way]  = 1'b1;
            tlb_dirty[way] = (wr == REQ_WRITE);
            tlb_tag[way]   = va;
            tlb_frame[way] = pfn;
            frame = pfn;
            r.hit = 1'b0;
        end

        // shift in 64 bits, then cut to the address width
        wide = {{(CALC_W-TAG_W){1'b0}}, frame} << cur_shift;
        r.phys_addr = wide[ADDR_W-1:0] | {{(ADDR_W-OFF_W){1'b0}}, off};
        r.slot = way[SLOT_W-1:0];
        return r;
    endfunction

    // Track transfers on both channels and the register writes
    always @(posedge clk or negedge rst_n)
    begin
        xlate_t want;
        int     k;

        if (!rst_n)
        begin
            cur_shift = SHIFT_RESET;
            for (k = 0; k < TLB_ENTRIES; k++)
            begin
                tlb_valid[k] = 1'b0;
                tlb_used[k]  = 1'b0;
                tlb_dirty[k] = 1'b0;
            end
            xlate_due.delete();
            xlate_pending  = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_we)
                cur_shift = cfg_wdata;

            if (in_valid && in_ready)
                xlate_due.push_back(translate_req(req_type, vpn, page_offset, refill_pfn));

            if (out_valid && out_ready)
            begin
                if (xlate_due.size() == 0)
                begin
                    $error("result transfer with nothing outstanding: phys_addr %h hit %b slot %0d",
                           phys_addr, hit, slot);
                    mismatch_count++;
                end
                else
                begin
                    want = xlate_due.pop_front();
                    if (phys_addr !== want.phys_addr)
                    begin
                        $error("phys_addr: expected %h, got %h", want.phys_addr, phys_addr);
                        mismatch_count++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %b, got %b", want.hit, hit);
                        mismatch_count++;
                    end
                    if (slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, slot);
                        mismatch_count++;
                    end
                end
            end

            xlate_pending = xlate_due.size();
        end
    end

endmodule

@@ verif/tlb_second_chance_unit_tb.sv @@
// Top of the TLB second-chance unit testbench: clock, reset, request and shift stimulus, verdict.
// Depends on tlbsc_pkg, tlb_second_chance_unit and tlb_second_chance_checker.
`timescale 1ns / 100ps

module tlb_second_chance_unit_tb;
    import tlbsc_pkg::*;

    localparam logic REQ_READ    = ~REQ_WRITE;
    localparam int   PHASES      = 6;
    localparam int   PHASE_ITEMS = 300;
    localparam int   POOL_MAX    = 32;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [SHIFT_W-1:0] cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic [TAG_W-1:0]   vpn;
    logic [OFF_W-1:0]   page_offset;
    logic [TAG_W-1:0]   refill_pfn;
    logic               out_valid;
    logic               out_ready;
    logic [ADDR_W-1:0]  phys_addr;
    logic               hit;
    logic [SLOT_W-1:0]  slot;

    int mismatch_count;
    int xlate_pending;
    int req_sent;

    tlb_second_chance_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .vpn         (vpn),
        .page_offset (page_offset),
        .refill_pfn  (refill_pfn),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .phys_addr   (phys_addr),
        .hit         (hit),
        .slot        (slot)
    );

    tlb_second_chance_checker u_xlate_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .vpn            (vpn),
        .page_offset    (page_offset),
        .refill_pfn     (refill_pfn),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .phys_addr      (phys_addr),
        .hit            (hit),
        .slot           (slot),
        .mismatch_count (mismatch_count),
        .xlate_pending  (xlate_pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [TAG_W-1:0] rand_frame();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[TAG_W-1:0];
    endfunction

    // mostly random, now and then an extreme
    function automatic logic [OFF_W-1:0] rand_off();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return OFF_W'($urandom());
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return rand_frame();
    endfunction

    // One request transfer after a random gap; every fourth run of 50 requests goes back to back
    task automatic send_req(logic wr, logic [TAG_W-1:0] va, logic [OFF_W-1:0] off,
                            logic [TAG_W-1:0] pfn);
        int gap;
        gap = (((req_sent / 50) % 4) == 2) ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= wr;
        vpn         <= va;
        page_offset <= off;
        refill_pfn  <= pfn;
        do @(posedge clk); while (!in_ready);
        req_sent++;
    endtask

    // Stop sending and wait until every translation has come back
    task automatic drain_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (xlate_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_shift(logic [SHIFT_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stall before each transfer; every fourth run of 64 results has no stalls
    initial
    begin
        int stall;
        int taken;
        out_ready = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = (((taken / 64) % 4) == 3) ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            taken++;
        end
    end

    // Request side and verdict
    initial
    begin
        logic [TAG_W-1:0]   vpn_pool [POOL_MAX];
        logic [SHIFT_W-1:0] shift_plan [PHASES];
        int                 k;
        int                 ph;
        int                 n;
        int                 sel;
        int                 pool_size;
        logic [TAG_W-1:0]   va;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        req_type    = REQ_READ;
        vpn         = '0;
        page_offset = '0;
        refill_pfn  = '0;
        req_sent    = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset shift
        // cold misses with field extremes, then hits on both
        send_req(REQ_READ, '0, '0, '0);
        send_req(REQ_WRITE, '1, '1, '1);
        send_req(REQ_READ, '0, '1, rand_frame());
        send_req(REQ_WRITE, '1, '0, rand_frame());
        // fill the remaining free entries
        for (k = 2; k < TLB_ENTRIES; k++)
            send_req(k[0], 36'h5_A5A5_0000 + k, rand_off(), rand_frame());
        // everything referenced: a whole pass clears, the second stops at entry 0
        send_req(REQ_READ, 36'h9_0000_0001, rand_off(), rand_frame());
        // touch one entry, then misses pick the first unreferenced entry
        send_req(REQ_WRITE, 36'h5_A5A5_0005, rand_off(), rand_frame());
        send_req(REQ_READ, 36'h9_0000_0002, rand_off(), rand_frame());
        send_req(REQ_WRITE, 36'h9_0000_0001, rand_off(), rand_frame());
        send_req(REQ_READ, 36'h9_0000_0003, rand_off(), rand_frame());
        drain_idle();

        // Random phases, one shift setting each; large shifts included
        shift_plan[0] = 5'd0;
        shift_plan[1] = 5'd27;
        shift_plan[2] = 5'd31;
        shift_plan[3] = 5'd28;
        shift_plan[4] = SHIFT_W'($urandom_range(0, 31));
        shift_plan[5] = 5'd1;
        for (ph = 0; ph < PHASES; ph++)
        begin
            write_shift(shift_plan[ph]);
            // working set around the table size gives hits, refills and sweeps
            pool_size = $urandom_range(6, 28);
            for (k = 0; k < POOL_MAX; k++)
                vpn_pool[k] = rand_tag();
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 78)
                    va = vpn_pool[$urandom_range(0, pool_size - 1)];
                else if (sel < 95)
                    va = rand_frame();
                else
                    va = sel[0] ? '1 : '0;
                send_req(1'($urandom_range(0, 1)), va, rand_off(), rand_tag());
            end
            drain_idle();
        end

        if (mismatch_count == 0 && xlate_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
